// File: sv/dgic_pkg.sv
// Shared types and constants of the delta group image channel decoder.
// Used by dgic_bitbuf and delta_group_image_channel_decoder; depends on nothing.
`default_nettype none

package dgic_pkg;

   localparam int BUF_WIDTH   = 16;
   localparam int HELD_WIDTH  = 5;
   localparam int COUNT_WIDTH = 4;

   localparam logic [4:0] BUF_FULL = 5'd16;

   localparam logic [3:0] LIT_WIDTH = 4'd8;
   localparam logic [3:0] HDR_WIDTH = 4'd3;
   localparam logic [3:0] EXT_WIDTH = 4'd1;

   localparam logic [2:0] HDR_RUN = 3'd0;
   localparam logic [2:0] HDR_EXT = 3'd7;

   localparam logic [2:0] GROUP_FIELDS = 3'd4;
   localparam logic [2:0] RUN_LENGTH   = 3'd4;
   localparam logic [3:0] MAX_RESULTS  = 4'd12;
   localparam logic [1:0] PLANE_LAST   = 2'd2;

   localparam logic [1:0] REG_WIDTH  = 2'd0;
   localparam logic [1:0] REG_HEIGHT = 2'd1;

   typedef struct packed {
      logic       clear;
      logic       load;
      logic [7:0] load_byte;
      logic       take;
      logic [3:0] take_count;
   } bit_ctrl_type;

   typedef struct packed {
      logic [4:0] bits_held;
      logic [7:0] value;
   } bit_stat_type;

endpackage

`default_nettype wire

// File: sv/dgic_bitbuf.sv
// Bit buffer of the decoder: shifts in stream bytes and hands out fields MSB first.
// Depends on dgic_pkg for its control and status structs.
`default_nettype none

module dgic_bitbuf (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire dgic_pkg::bit_ctrl_type ctrl,
   output dgic_pkg::bit_stat_type     stat
);

   logic [15:0] bit_buffer_ff;
   logic [4:0]  bits_held_ff;
   logic [4:0]  held_left;
   logic [16:0] keep_mask;
   logic [15:0] shifted;
   logic [8:0]  take_mask;

   always_comb begin
      held_left = bits_held_ff - 5'(ctrl.take_count);
      keep_mask = (17'd1 << held_left) - 17'd1;
      shifted   = bit_buffer_ff >> held_left;
      take_mask = (9'd1 << ctrl.take_count) - 9'd1;
   end

   assign stat.bits_held = bits_held_ff;
   assign stat.value     = shifted[7:0] & take_mask[7:0];

   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         bit_buffer_ff <= '0;
         bits_held_ff  <= '0;
      end else if (ctrl.load) begin
         bit_buffer_ff <= {bit_buffer_ff[7:0], ctrl.load_byte};
         bits_held_ff  <= (bits_held_ff >= 5'd8) ? dgic_pkg::BUF_FULL : bits_held_ff + 5'd8;
      end else if (ctrl.take) begin
         bit_buffer_ff <= bit_buffer_ff & keep_mask[15:0];
         bits_held_ff  <= held_left;
      end
   end

   a_held_range: assert property (@(posedge clock) disable iff (reset)
      bits_held_ff <= dgic_pkg::BUF_FULL)
      else $error("bit count beyond buffer size");

   a_take_enough: assert property (@(posedge clock) disable iff (reset)
      ctrl.take |-> (5'(ctrl.take_count) <= bits_held_ff && ctrl.take_count != 4'd0))
      else $error("field taken with too few bits held");

endmodule

`default_nettype wire

// File: sv/delta_group_image_channel_decoder.sv
// Delta group image channel decoder: turns stream bytes into serpentine-ordered samples.
// Depends on dgic_pkg and instantiates dgic_bitbuf.
//
// Each accepted byte is decoded by a small sequencer around one shared bit extractor: it
// accepts the byte, takes each literal, header, field or run sample in turn, then closes
// the transfer group; a stalled result side holds any step that emits a sample. A byte
// can yield up to twelve samples and the last one carries run_last. Writing either size
// register restarts decoding of a new image; after the final sample of the third plane
// further bytes are accepted and ignored.
`default_nettype none

module delta_group_image_channel_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_stream_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_pixel_x,
   output logic [15:0]      rsp_pixel_y,
   output logic [1:0]       rsp_component,
   output logic [7:0]       rsp_sample_value,
   output logic             rsp_run_last,
   output logic             rsp_image_done,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   typedef enum logic [1:0] {ST_IDLE, ST_DECODE, ST_RUN, ST_FLUSH} state_type;
   typedef enum logic [2:0] {PH_LIT, PH_HDR, PH_EXT, PH_FIELD, PH_DROP, PH_DONE} phase_type;

   state_type   state_ff;
   phase_type   phase_ff;
   logic [15:0] width_ff, height_ff;
   logic [7:0]  current_ff;
   logic [3:0]  field_width_ff;
   logic [2:0]  fields_left_ff;
   logic [2:0]  run_count_ff;
   logic [1:0]  plane_ff;
   logic        plane_done_ff;
   logic [15:0] col_ff, row_ff;
   logic        finished_ff;
   logic [3:0]  count_ff;

   logic        hold_valid_ff;
   logic [15:0] hold_x_ff, hold_y_ff;
   logic [1:0]  hold_comp_ff;
   logic [7:0]  hold_value_ff;
   logic        hold_done_ff;

   logic        rsp_valid_ff;
   logic [15:0] rsp_x_ff, rsp_y_ff;
   logic [1:0]  rsp_comp_ff;
   logic [7:0]  rsp_value_ff;
   logic        rsp_last_ff;
   logic        rsp_done_ff;

   dgic_pkg::bit_ctrl_type bit_ctrl;
   dgic_pkg::bit_stat_type bit_stat;

   logic [3:0]  need;
   logic        have_bits, emit_needed, out_free, can_emit;
   logic        step_go, step_end, run_go, run_emit, emit, is_last, adv_plane;
   logic        push, push_last, req_fire, csr_fire;
   logic [7:0]  v, half, field_value, emit_value;
   logic [15:0] emit_x;

   assign v = bit_stat.value;

   always_comb begin
      unique case (phase_ff)
         PH_LIT:  need = dgic_pkg::LIT_WIDTH;
         PH_HDR:  need = dgic_pkg::HDR_WIDTH;
         PH_EXT:  need = dgic_pkg::EXT_WIDTH;
         default: need = field_width_ff;
      endcase
   end

   always_comb begin
      half        = {1'b0, v[7:1]};
      if (field_width_ff == dgic_pkg::LIT_WIDTH) begin
         field_value = v;
      end else if (v[0]) begin
         field_value = current_ff + half + 8'd1;
      end else begin
         field_value = current_ff - half;
      end
      have_bits   = (need != 4'd0) && (need <= dgic_pkg::LIT_WIDTH)
                    && (bit_stat.bits_held >= 5'(need));
      emit_needed = ((phase_ff == PH_LIT) && !plane_done_ff) || (phase_ff == PH_FIELD);
      out_free    = !rsp_valid_ff || rsp_ready;
      can_emit    = !hold_valid_ff || out_free;
      step_go     = (state_ff == ST_DECODE) && !finished_ff && (count_ff != dgic_pkg::MAX_RESULTS)
                    && have_bits && (!emit_needed || can_emit);
      step_end    = (state_ff == ST_DECODE) && (finished_ff
                    || (count_ff == dgic_pkg::MAX_RESULTS) || !have_bits);
      run_go      = (state_ff == ST_RUN) && (run_count_ff != dgic_pkg::RUN_LENGTH)
                    && !plane_done_ff && (count_ff != dgic_pkg::MAX_RESULTS);
      run_emit    = run_go && can_emit;
      emit        = (step_go && emit_needed) || run_emit;
      is_last     = (col_ff == width_ff - 16'd1) && (row_ff == height_ff - 16'd1);
      emit_x      = row_ff[0] ? (width_ff - 16'd1 - col_ff) : col_ff;
      if (state_ff == ST_RUN) begin
         emit_value = current_ff;
      end else if (phase_ff == PH_LIT) begin
         emit_value = v;
      end else begin
         emit_value = field_value;
      end
      adv_plane   = (step_go && (((phase_ff == PH_LIT) && !plane_done_ff && is_last)
                    || ((phase_ff == PH_FIELD) && is_last && (fields_left_ff == 3'd1))
                    || (phase_ff == PH_DROP)))
                    || ((state_ff == ST_RUN) && !run_go && plane_done_ff);
      push_last   = (state_ff == ST_FLUSH);
      push        = (emit && hold_valid_ff) || (push_last && hold_valid_ff && out_free);
      req_fire    = req_valid && req_ready;
      csr_fire    = csr_valid && csr_ready;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   always_comb begin
      bit_ctrl.clear      = csr_fire && ((csr_index == dgic_pkg::REG_WIDTH)
                            || (csr_index == dgic_pkg::REG_HEIGHT));
      bit_ctrl.load       = req_fire && !finished_ff;
      bit_ctrl.load_byte  = req_stream_byte;
      bit_ctrl.take       = step_go;
      bit_ctrl.take_count = need;
   end

   dgic_bitbuf u_bitbuf (
      .clock (clock),
      .reset (reset),
      .ctrl  (bit_ctrl),
      .stat  (bit_stat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         phase_ff       <= PH_LIT;
         width_ff       <= 16'd1;
         height_ff      <= 16'd1;
         current_ff     <= '0;
         field_width_ff <= '0;
         fields_left_ff <= '0;
         run_count_ff   <= '0;
         plane_ff       <= '0;
         plane_done_ff  <= 1'b0;
         col_ff         <= '0;
         row_ff         <= '0;
         finished_ff    <= 1'b0;
         count_ff       <= '0;
         hold_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (push) begin
            rsp_valid_ff <= 1'b1;
            rsp_x_ff     <= hold_x_ff;
            rsp_y_ff     <= hold_y_ff;
            rsp_comp_ff  <= hold_comp_ff;
            rsp_value_ff <= hold_value_ff;
            rsp_done_ff  <= hold_done_ff;
            rsp_last_ff  <= push_last;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (emit) begin
            hold_valid_ff <= 1'b1;
            hold_x_ff     <= emit_x;
            hold_y_ff     <= row_ff;
            hold_comp_ff  <= plane_ff;
            hold_value_ff <= emit_value;
            hold_done_ff  <= (plane_ff == dgic_pkg::PLANE_LAST) && is_last;
            count_ff      <= count_ff + 4'd1;
            plane_done_ff <= is_last;
            if (col_ff == width_ff - 16'd1) begin
               col_ff <= '0;
               row_ff <= row_ff + 16'd1;
            end else begin
               col_ff <= col_ff + 16'd1;
            end
         end else if (push) begin
            hold_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (csr_fire && bit_ctrl.clear) begin
                  if (csr_index == dgic_pkg::REG_WIDTH) begin
                     width_ff      <= csr_data;
                     plane_done_ff <= (csr_data == 16'd0) || (height_ff == 16'd0);
                  end else begin
                     height_ff     <= csr_data;
                     plane_done_ff <= (csr_data == 16'd0) || (width_ff == 16'd0);
                  end
                  phase_ff       <= PH_LIT;
                  current_ff     <= '0;
                  field_width_ff <= '0;
                  fields_left_ff <= '0;
                  plane_ff       <= '0;
                  col_ff         <= '0;
                  row_ff         <= '0;
                  finished_ff    <= 1'b0;
               end else if (req_fire && !finished_ff) begin
                  count_ff <= '0;
                  state_ff <= ST_DECODE;
               end
            end
            ST_DECODE: begin
               if (step_go) begin
                  unique case (phase_ff)
                     PH_LIT: begin
                        current_ff <= v;
                        if (plane_done_ff) begin
                           finished_ff <= 1'b1;
                           phase_ff    <= PH_DONE;
                        end else begin
                           phase_ff <= PH_HDR;
                        end
                     end
                     PH_HDR: begin
                        if (v[2:0] == dgic_pkg::HDR_RUN) begin
                           run_count_ff <= '0;
                           state_ff     <= ST_RUN;
                        end else if (v[2:0] == dgic_pkg::HDR_EXT) begin
                           phase_ff <= PH_EXT;
                        end else begin
                           field_width_ff <= {1'b0, v[2:0]} + 4'd2;
                           fields_left_ff <= dgic_pkg::GROUP_FIELDS;
                           phase_ff       <= PH_FIELD;
                        end
                     end
                     PH_EXT: begin
                        field_width_ff <= {3'b000, v[0]} + 4'd1;
                        fields_left_ff <= dgic_pkg::GROUP_FIELDS;
                        phase_ff       <= PH_FIELD;
                     end
                     PH_FIELD: begin
                        current_ff     <= field_value;
                        fields_left_ff <= fields_left_ff - 3'd1;
                        if (is_last && (fields_left_ff != 3'd1)) begin
                           phase_ff <= PH_DROP;
                        end else if (fields_left_ff == 3'd1) begin
                           phase_ff <= PH_HDR;
                        end
                     end
                     PH_DROP: begin
                        fields_left_ff <= '0;
                     end
                     default: begin
                        phase_ff <= PH_DONE;
                     end
                  endcase
               end else if (step_end) begin
                  state_ff <= ST_FLUSH;
               end
            end
            ST_RUN: begin
               if (run_emit) begin
                  run_count_ff <= run_count_ff + 3'd1;
               end else if (!run_go) begin
                  state_ff <= ST_DECODE;
               end
            end
            ST_FLUSH: begin
               if (!hold_valid_ff || out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if (adv_plane) begin
            if (plane_ff == dgic_pkg::PLANE_LAST) begin
               finished_ff <= 1'b1;
               phase_ff    <= PH_DONE;
            end else begin
               plane_ff      <= plane_ff + 2'd1;
               plane_done_ff <= 1'b0;
               col_ff        <= '0;
               row_ff        <= '0;
               phase_ff      <= PH_LIT;
            end
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = rsp_x_ff;
   assign rsp_pixel_y      = rsp_y_ff;
   assign rsp_component    = rsp_comp_ff;
   assign rsp_sample_value = rsp_value_ff;
   assign rsp_run_last     = rsp_last_ff;
   assign rsp_image_done   = rsp_done_ff;

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !hold_valid_ff)
      else $error("pending sample left behind at end of byte");

   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dgic_pkg::MAX_RESULTS)
      else $error("too many samples for one byte");

   a_emit_in_plane: assert property (@(posedge clock) disable iff (reset)
      emit |-> (!plane_done_ff && !finished_ff))
      else $error("sample produced past the end of a plane");

   a_flush_marks_last: assert property (@(posedge clock) disable iff (reset)
      (push && (state_ff == ST_FLUSH)) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("closing transfer lost its run_last flag");

endmodule

`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for delta_group_image_channel_decoder: it drives stream bytes and
// size registers, predicts every decoded sample and compares each result transfer.
// Depends on dgic_pkg and on the decoder RTL.

module tb_top;
   import dgic_pkg::*;

   localparam int LIMIT_CYCLES  = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int MAX_REPORTS   = 40;
   localparam int RANDOM_BYTES  = 440;

   localparam logic [1:0] REG_UNUSED_A = 2'd2;
   localparam logic [1:0] REG_UNUSED_B = 2'd3;

   typedef enum logic [2:0] {
      AWAIT_LITERAL, AWAIT_HEADER, AWAIT_EXTENSION, AWAIT_FIELD, DROP_FIELD, IMAGE_FINISHED
   } decode_phase_t;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [1:0]  component;
      logic [7:0]  sample_value;
      logic        run_last;
      logic        image_done;
   } sample_t;

   typedef struct packed {
      logic [1:0]  index;
      logic [15:0] data;
   } reg_write_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_pixel_x;
   logic [15:0] rsp_pixel_y;
   logic [1:0]  rsp_component;
   logic [7:0]  rsp_sample_value;
   logic        rsp_run_last;
   logic        rsp_image_done;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [15:0] csr_data = 16'd0;

   delta_group_image_channel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_component    (rsp_component),
      .rsp_sample_value (rsp_sample_value),
      .rsp_run_last     (rsp_run_last),
      .rsp_image_done   (rsp_image_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Decoder state as the predictor tracks it.
   logic [15:0]   image_width_q = 16'd1;
   logic [15:0]   image_height_q = 16'd1;
   logic [15:0]   bit_window;
   logic [4:0]    bits_held;
   logic [7:0]    current_value;
   decode_phase_t phase;
   logic [3:0]    field_width;
   logic [2:0]    fields_left;
   logic [1:0]    plane_index;
   logic [31:0]   samples_left;
   logic [15:0]   col_pos;
   logic [15:0]   row_pos;
   logic          image_finished;

   sample_t     pending_samples[$];
   reg_write_t  reg_writes[$];
   bit          stream_bits[$];
   int          byte_samples;
   int          bytes_sent = 0;
   int unsigned mismatches = 0;
   int          cycle_count;
   bit          quiet = 1'b0;

   function automatic void restart_image();
      bit_window = '0;
      bits_held = '0;
      current_value = '0;
      phase = AWAIT_LITERAL;
      field_width = '0;
      fields_left = '0;
      plane_index = '0;
      samples_left = 32'(image_width_q) * 32'(image_height_q);
      col_pos = '0;
      row_pos = '0;
      image_finished = 1'b0;
   endfunction

   function automatic logic [7:0] take_bits(input int unsigned count);
      int unsigned window;
      int unsigned value;
      window = bit_window;
      value = (window >> (bits_held - count)) & ((1 << count) - 1);
      bits_held = bits_held - 5'(count);
      window = window & ((32'd1 << bits_held) - 1);
      bit_window = window[15:0];
      return value[7:0];
   endfunction

   function automatic void next_plane();
      if (plane_index >= PLANE_LAST) begin
         image_finished = 1'b1;
         phase = IMAGE_FINISHED;
      end else begin
         plane_index++;
         samples_left = 32'(image_width_q) * 32'(image_height_q);
         col_pos = '0;
         row_pos = '0;
         phase = AWAIT_LITERAL;
      end
   endfunction

   function automatic void queue_sample();
      sample_t s;
      s.pixel_x = row_pos[0] ? image_width_q - 16'd1 - col_pos : col_pos;
      s.pixel_y = row_pos;
      s.component = plane_index;
      s.sample_value = current_value;
      s.run_last = 1'b0;
      samples_left--;
      s.image_done = (plane_index == PLANE_LAST) && (samples_left == 0);
      col_pos++;
      if (col_pos >= image_width_q) begin
         col_pos = '0;
         row_pos++;
      end
      pending_samples.push_back(s);
      byte_samples++;
   endfunction

   function automatic void decode_byte(input logic [7:0] stream_byte);
      int unsigned need;
      logic [7:0]  code;
      int          k;
      sample_t     s;
      byte_samples = 0;
      if (image_finished) return;
      bit_window = {bit_window[7:0], stream_byte};
      bits_held = (bits_held + 5'd8 > 5'd16) ? 5'd16 : bits_held + 5'd8;
      while (!image_finished && byte_samples < MAX_RESULTS) begin
         case (phase)
            AWAIT_LITERAL:   need = LIT_WIDTH;
            AWAIT_HEADER:    need = HDR_WIDTH;
            AWAIT_EXTENSION: need = EXT_WIDTH;
            default:         need = field_width;
         endcase
         if (need == 0 || need > 8 || bits_held < need) break;
         code = take_bits(need);
         case (phase)
            AWAIT_LITERAL: begin
               current_value = code;
               if (samples_left == 0) begin
                  image_finished = 1'b1;
                  phase = IMAGE_FINISHED;
               end else begin
                  queue_sample();
                  if (samples_left == 0) next_plane();
                  else phase = AWAIT_HEADER;
               end
            end
            AWAIT_HEADER: begin
               if (code[2:0] == HDR_RUN) begin
                  for (k = 0; k < RUN_LENGTH && samples_left != 0 && byte_samples < MAX_RESULTS;
                       k++)
                     queue_sample();
                  if (samples_left == 0) next_plane();
               end else if (code[2:0] == HDR_EXT) begin
                  phase = AWAIT_EXTENSION;
               end else begin
                  field_width = code[3:0] + 4'd2;
                  fields_left = GROUP_FIELDS;
                  phase = AWAIT_FIELD;
               end
            end
            AWAIT_EXTENSION: begin
               field_width = code[3:0] + 4'd1;
               fields_left = GROUP_FIELDS;
               phase = AWAIT_FIELD;
            end
            AWAIT_FIELD: begin
               if (field_width == LIT_WIDTH)
                  current_value = code;
               else if (code[0])
                  current_value = current_value + {1'b0, code[7:1]} + 8'd1;
               else
                  current_value = current_value - {1'b0, code[7:1]};
               fields_left--;
               queue_sample();
               if (samples_left == 0) begin
                  if (fields_left != 0) phase = DROP_FIELD;
                  else next_plane();
               end else if (fields_left == 0) begin
                  phase = AWAIT_HEADER;
               end
            end
            default: begin
               fields_left = '0;
               next_plane();
            end
         endcase
      end
      if (byte_samples > 0) begin
         s = pending_samples.pop_back();
         s.run_last = 1'b1;
         pending_samples.push_back(s);
      end
   endfunction

   function automatic void write_size_reg(input logic [1:0] index, input logic [15:0] data);
      if (index == REG_WIDTH) begin
         image_width_q = data;
         restart_image();
      end else if (index == REG_HEIGHT) begin
         image_height_q = data;
         restart_image();
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch in %s at cycle %0d: got %0d, expected %0d",
                  what, cycle_count, got, want);
   endtask

   task automatic check_sample();
      sample_t want;
      if (pending_samples.size() == 0) begin
         report_mismatch("unexpected sample transfer", rsp_sample_value, 0);
         return;
      end
      want = pending_samples.pop_front();
      if (rsp_pixel_x !== want.pixel_x) report_mismatch("pixel_x", rsp_pixel_x, want.pixel_x);
      if (rsp_pixel_y !== want.pixel_y) report_mismatch("pixel_y", rsp_pixel_y, want.pixel_y);
      if (rsp_component !== want.component)
         report_mismatch("component", rsp_component, want.component);
      if (rsp_sample_value !== want.sample_value)
         report_mismatch("sample_value", rsp_sample_value, want.sample_value);
      if (rsp_run_last !== want.run_last)
         report_mismatch("run_last", rsp_run_last, want.run_last);
      if (rsp_image_done !== want.image_done)
         report_mismatch("image_done", rsp_image_done, want.image_done);
   endtask

   // Results are checked before the byte of the same edge is decoded.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_sample();
         if (req_valid && req_ready) decode_byte(req_stream_byte);
         if (csr_valid && csr_ready) write_size_reg(csr_index, csr_data);
      end
   end

   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 7);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   task automatic send_byte(input logic [7:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_stream_byte <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic put_bits(input int unsigned value, input int count);
      int         i;
      logic [7:0] next_byte;
      for (i = count - 1; i >= 0; i--) stream_bits.push_back(value[i]);
      while (stream_bits.size() >= 8) begin
         for (i = 0; i < 8; i++) next_byte = {next_byte[6:0], stream_bits.pop_front()};
         send_byte(next_byte);
      end
   endtask

   task automatic flush_bits();
      while (stream_bits.size() % 8 != 0) stream_bits.push_back($urandom_range(0, 1));
      put_bits(0, 0);
   endtask

   task automatic put_coded_header(input int width);
      if (width <= 2) begin
         put_bits(HDR_EXT, 3);
         put_bits(width - 1, 1);
      end else begin
         put_bits(width - 2, 3);
      end
   endtask

   // Lowers the byte stream and lets the decoder drain before any register write.
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_writes();
      reg_write_t wr;
      while (reg_writes.size() != 0) begin
         wr = reg_writes.pop_front();
         csr_valid <= 1'b1;
         csr_index <= wr.index;
         csr_data <= wr.data;
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic set_size(input logic [15:0] width, input logic [15:0] height);
      settle();
      if ($urandom_range(0, 1)) begin
         reg_writes.push_back('{REG_WIDTH, width});
         reg_writes.push_back('{REG_HEIGHT, height});
      end else begin
         reg_writes.push_back('{REG_HEIGHT, height});
         reg_writes.push_back('{REG_WIDTH, width});
      end
      apply_writes();
   endtask

   task automatic send_random_image(input int plane_size, input bit broken);
      int p;
      int left;
      int hdr;
      int width;
      int count;
      int k;
      int cut_plane;
      cut_plane = broken ? $urandom_range(0, 2) : 3;
      for (p = 0; p < 3; p++) begin
         if (p == cut_plane)
            repeat ($urandom_range(1, 24)) put_bits($urandom_range(0, 1), 1);
         put_bits($urandom_range(0, 255), 8);
         left = plane_size - 1;
         while (left > 0) begin
            hdr = $urandom_range(0, 7);
            if (hdr == HDR_RUN) begin
               put_bits(HDR_RUN, 3);
            end else begin
               width = (hdr == HDR_EXT) ? $urandom_range(1, 2) : hdr + 2;
               put_coded_header(width);
               // A group cut off by the plane end carries one extra field that is dropped.
               count = (left < 4) ? left + 1 : 4;
               for (k = 0; k < count; k++)
                  put_bits($urandom_range(0, (1 << width) - 1), width);
            end
            left -= (left < 4) ? left : 4;
         end
      end
      flush_bits();
   endtask

   // Power-up size is one pixel, so each byte is a whole plane.
   task automatic test_reset_defaults();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA5);
      send_byte(8'h5A);
   endtask

   task automatic test_coded_groups();
      set_size(16'd2, 16'd2);
      put_bits(8'hFF, 8);
      put_coded_header(3);
      put_bits(7, 3);
      put_bits(6, 3);
      put_bits(HDR_RUN, 3);
      put_bits(8'h00, 8);
      put_coded_header(8);
      put_bits(8'hFF, 8);
      put_bits(8'h80, 8);
      put_bits(8'h01, 8);
      put_bits(8'h00, 8);
      put_bits(8'h00, 8);
      put_coded_header(1);
      put_bits(1, 1);
      put_bits(0, 1);
      put_coded_header(2);
      put_bits(2, 2);
      put_bits(3, 2);
      flush_bits();
   endtask

   task automatic test_group_widths();
      set_size(16'd2, 16'd2);
      put_bits(8'h02, 8);
      put_coded_header(4);
      put_bits(8, 4);
      put_bits(15, 4);
      put_bits(9, 4);
      put_bits(10, 4);
      put_bits(8'hF0, 8);
      put_coded_header(5);
      put_bits(31, 5);
      put_bits(30, 5);
      put_bits(0, 5);
      put_bits(21, 5);
      put_bits(8'h7F, 8);
      put_coded_header(7);
      put_bits(127, 7);
      put_bits(0, 7);
      put_bits(64, 7);
      put_bits(85, 7);
      flush_bits();
   endtask

   task automatic test_zero_size();
      set_size(16'd0, 16'd3);
      send_byte(8'h12);
      send_byte(8'h34);
   endtask

   task automatic test_size_extremes();
      int widths[6]  = '{65535, 1, 65535, 4, 0, 3};
      int heights[6] = '{1, 65535, 65535, 0, 0, 3};
      int i;
      for (i = 0; i < 6; i++) begin
         set_size(widths[i], heights[i]);
         repeat (8) send_byte($urandom_range(0, 255));
      end
      // Writes to unused register indexes must leave the current image running.
      settle();
      reg_writes.push_back('{REG_UNUSED_A, 16'($urandom_range(0, 65535))});
      reg_writes.push_back('{REG_UNUSED_B, 16'($urandom_range(0, 65535))});
      apply_writes();
      repeat (8) send_byte($urandom_range(0, 255));
   endtask

   task automatic test_random_images();
      int width;
      int height;
      while (bytes_sent < RANDOM_BYTES) begin
         quiet = ($urandom_range(0, 3) == 0);
         width = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
         height = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         set_size(width, height);
         send_random_image(width * height, $urandom_range(0, 5) == 0);
      end
   endtask

   task automatic test_random_noise();
      repeat (4) begin
         quiet = ($urandom_range(0, 3) == 0);
         set_size($urandom_range(0, 5), $urandom_range(0, 5));
         repeat (15) send_byte($urandom_range(0, 255));
      end
   endtask

   initial begin
      restart_image();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_coded_groups();
      test_group_widths();
      test_zero_size();
      test_size_extremes();
      test_random_images();
      test_random_noise();
      settle();
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
